[src/ckr_pkg.sv]
// Shared types and constants for the color-key run-to-rectangle block.
// No dependencies; imported by every module of the block.
package ckr_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int BATCH_SIZE = 2000;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [3:0] {
		REG_KEY_RED    = 4'd0,
		REG_KEY_GREEN  = 4'd1,
		REG_KEY_BLUE   = 4'd2,
		REG_TOL_RED    = 4'd3,
		REG_TOL_GREEN  = 4'd4,
		REG_TOL_BLUE   = 4'd5,
		REG_IMG_WIDTH  = 4'd6,
		REG_IMG_HEIGHT = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
	} pix_t;

	typedef struct packed {
		logic        rect_valid;
		logic [11:0] rect_left;
		logic [12:0] rect_right;
		logic [11:0] rect_row;
		logic        batch_end;
		logic [10:0] batch_count;
		logic [12:0] bound_left;
		logic [12:0] bound_top;
		logic [12:0] bound_right;
		logic [12:0] bound_bottom;
		logic        image_end;
	} rect_t;

	// Settings seen by the front end; dimensions held as last index.
	typedef struct packed {
		logic [7:0]  key_red;
		logic [7:0]  key_green;
		logic [7:0]  key_blue;
		logic [7:0]  tol_red;
		logic [7:0]  tol_green;
		logic [7:0]  tol_blue;
		logic [11:0] col_last;
		logic [11:0] row_last;
	} cfg_t;

	// Run event handed from front to back.
	typedef struct packed {
		logic        have;
		logic [11:0] left;
		logic [12:0] right;
		logic [11:0] row;
		logic        last_img;
	} tok_t;

endpackage

[src/ckr_front.sv]
// Front end: accepts pixels, keys them, tracks column/row and open runs.
// Depends on ckr_pkg; pushes run events into ckr_fifo.
module ckr_front
	import ckr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  pix_t pix,
	input  cfg_t cfg,
	input  logic q_full,
	output logic push,
	output tok_t tok
);

	logic [11:0] col_q, row_q, run_start_q;
	logic        in_run_q;
	logic        accept, clear, last_col, last_img;
	logic [11:0] start;

	function automatic logic in_band(input logic [7:0] p, input logic [7:0] key,
			input logic [7:0] tol);
		logic [8:0] hi;
		hi = {1'b0, key} + {1'b0, tol};
		if (hi > 9'd255) hi = 9'd255;
		return (p >= key) && ({1'b0, p} <= hi);
	endfunction

	assign pix_stall = q_full;
	assign accept    = pix_valid && !q_full;
	assign clear     = in_band(pix.pix_red, cfg.key_red, cfg.tol_red)
		&& in_band(pix.pix_green, cfg.key_green, cfg.tol_green)
		&& in_band(pix.pix_blue, cfg.key_blue, cfg.tol_blue);
	assign last_col  = col_q >= cfg.col_last;
	assign last_img  = last_col && (row_q >= cfg.row_last);
	assign start     = in_run_q ? run_start_q : col_q;

	always_comb begin
		tok          = '0;
		tok.row      = row_q;
		tok.last_img = last_img;
		if (clear) begin
			if (in_run_q) begin
				tok.have  = 1'b1;
				tok.left  = run_start_q;
				tok.right = {1'b0, col_q};
			end
		end else if (last_col) begin
			tok.have  = 1'b1;
			tok.left  = start;
			tok.right = {1'b0, col_q} + 13'd1;
		end
		push = accept && (tok.have || last_img);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			in_run_q    <= 1'b0;
			run_start_q <= '0;
		end else if (accept) begin
			in_run_q    <= !clear && !last_col;
			run_start_q <= last_img ? 12'd0 : start;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_img ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

endmodule

[src/ckr_fifo.sv]
// Short event queue between front and back ends.
// Depends on ckr_pkg for the event type and depth.
module ckr_fifo
	import ckr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t wr_tok,
	output logic full,
	input  logic pop,
	output tok_t rd_tok,
	output logic empty
);

	tok_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push, do_pop;

	assign full    = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_tok  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/ckr_back.sv]
// Back end: batch counting, bounding box, and the output register.
// Depends on ckr_pkg; pops run events from ckr_fifo.
module ckr_back
	import ckr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  tok_t  tok,
	output logic  pop,
	output logic  res_valid,
	input  logic  res_stall,
	output rect_t res
);

	localparam logic [12:0] DimVal = 13'(MAX_DIM);

	logic [10:0] rects_q, cnt_n;
	logic [12:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
	logic [12:0] bl_n, bt_n, br_n, bb_n, row_w, row_p1;
	logic        close;
	logic        res_valid_q;
	rect_t       res_q, res_n;

	assign pop    = !q_empty && (!res_valid_q || !res_stall);
	assign row_w  = {1'b0, tok.row};
	assign row_p1 = row_w + 13'd1;

	always_comb begin
		cnt_n = rects_q;
		bl_n  = box_left_q;
		bt_n  = box_top_q;
		br_n  = box_right_q;
		bb_n  = box_bottom_q;
		if (tok.have) begin
			cnt_n = rects_q + 11'd1;
			if ({1'b0, tok.left} < box_left_q) bl_n = {1'b0, tok.left};
			if (row_w < box_top_q) bt_n = row_w;
			if (tok.right > box_right_q) br_n = tok.right;
			if (row_p1 > box_bottom_q) bb_n = row_p1;
		end
		close = (tok.have && (cnt_n >= 11'(BATCH_SIZE))) || tok.last_img;

		res_n = '0;
		if (tok.have) begin
			res_n.rect_valid = 1'b1;
			res_n.rect_left  = tok.left;
			res_n.rect_right = tok.right;
			res_n.rect_row   = tok.row;
		end
		if (close) begin
			res_n.batch_end    = 1'b1;
			res_n.batch_count  = cnt_n;
			res_n.bound_left   = bl_n;
			res_n.bound_top    = bt_n;
			res_n.bound_right  = br_n;
			res_n.bound_bottom = bb_n;
		end
		res_n.image_end = tok.last_img;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rects_q      <= '0;
			box_left_q   <= DimVal;
			box_top_q    <= DimVal;
			box_right_q  <= '0;
			box_bottom_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
				if (close) begin
					rects_q      <= '0;
					box_left_q   <= DimVal;
					box_top_q    <= DimVal;
					box_right_q  <= '0;
					box_bottom_q <= '0;
				end else begin
					rects_q      <= cnt_n;
					box_left_q   <= bl_n;
					box_top_q    <= bt_n;
					box_right_q  <= br_n;
					box_bottom_q <= bb_n;
				end
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= res_n;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_batch_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		rects_q < 11'(BATCH_SIZE))
		else $error("batch count reached full size without closing");

	a_image_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && tok.last_img |=> rects_q == '0 && box_right_q == '0)
		else $error("batch not cleared after last pixel");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		rects_q == '0 |-> box_left_q == DimVal && box_bottom_q == '0)
		else $error("empty batch holds a nonempty box");

	a_close_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pop && close |=> res_q.batch_end && res_valid_q)
		else $error("batch close lost on the output register");
`endif

endmodule

[src/color_key_run_to_rects_top.sv]
// Channel  Dir  Handshake             Beat
// pix      in   pix_valid/pix_stall   one RGB pixel, raster order
// res      out  res_valid/res_stall   run rectangle and/or batch close
// cfg      in   cfg_we                register write, cfg_idx/cfg_data
//
// One pixel per cycle while pix_stall is low; a result passes through the event queue and the output register.
// Front end keys pixels and tracks runs; a 4-entry event queue feeds the back
// end, which owns batch counting and the output register.
// Pixels that end no run and are not the last of the image make no event.
// pix_stall rises only when the event queue is full.
// Reset clears counters, the open run, the batch and all settings.
// Top level: settings registers and the front/queue/back chain.
// Depends on ckr_pkg, ckr_front, ckr_fifo, ckr_back.
module color_key_run_to_rects_top
	import ckr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  pix_t        pix,
	output logic        res_valid,
	input  logic        res_stall,
	output rect_t       res,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_idx,
	input  logic [12:0] cfg_data
);

	cfg_t cfg_q;
	tok_t push_tok, pop_tok;
	logic push, pop, q_full, q_empty;

	// Width/height of 0 act as 1, above the max act as the max.
	function automatic logic [11:0] dim_last(input logic [12:0] v);
		logic [12:0] c;
		c = v;
		if (c == 13'd0) c = 13'd1;
		if (c > 13'(MAX_DIM)) c = 13'(MAX_DIM);
		return 12'(c - 13'd1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_KEY_RED:    cfg_q.key_red   <= cfg_data[7:0];
				REG_KEY_GREEN:  cfg_q.key_green <= cfg_data[7:0];
				REG_KEY_BLUE:   cfg_q.key_blue  <= cfg_data[7:0];
				REG_TOL_RED:    cfg_q.tol_red   <= cfg_data[7:0];
				REG_TOL_GREEN:  cfg_q.tol_green <= cfg_data[7:0];
				REG_TOL_BLUE:   cfg_q.tol_blue  <= cfg_data[7:0];
				REG_IMG_WIDTH:  cfg_q.col_last  <= dim_last(cfg_data);
				REG_IMG_HEIGHT: cfg_q.row_last  <= dim_last(cfg_data);
				default:        cfg_q           <= cfg_q;
			endcase
		end
	end

	ckr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.tok       (push_tok)
	);

	ckr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_tok (push_tok),
		.full   (q_full),
		.pop    (pop),
		.rd_tok (pop_tok),
		.empty  (q_empty)
	);

	ckr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.tok       (pop_tok),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

[tb/testbench.sv]
// Self-checking testbench for color_key_run_to_rects_top: keyed RGB pixels in, run rectangles
// and batch bounding boxes out, each beat checked against a cycle-free model of the block.
// Depends on ckr_pkg and the RTL under src/.
module testbench;
	import ckr_pkg::*;

	// Tracks the run/batch state of the block and holds the rectangles still due.
	class run_rect_tracker;
		logic [7:0]  key [3];
		logic [7:0]  tol [3];
		logic [12:0] width_reg, height_reg;
		int col_count, row_count, run_start, rects_in_batch;
		bit in_run;
		int box_left, box_top, box_right, box_bottom;
		rect_t rects_due [$];
		int errors;

		function new();
			for (int c = 0; c < 3; c++) begin
				key[c] = '0;
				tol[c] = '0;
			end
			width_reg = 13'd1;
			height_reg = 13'd1;
			col_count = 0;
			row_count = 0;
			run_start = 0;
			in_run = 0;
			errors = 0;
			clear_batch();
		endfunction

		function void clear_batch();
			rects_in_batch = 0;
			box_left = MAX_DIM;
			box_top = MAX_DIM;
			box_right = 0;
			box_bottom = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [12:0] data);
			case (idx)
				REG_KEY_RED: key[0] = data[7:0];
				REG_KEY_GREEN: key[1] = data[7:0];
				REG_KEY_BLUE: key[2] = data[7:0];
				REG_TOL_RED: tol[0] = data[7:0];
				REG_TOL_GREEN: tol[1] = data[7:0];
				REG_TOL_BLUE: tol[2] = data[7:0];
				REG_IMG_WIDTH: width_reg = data;
				REG_IMG_HEIGHT: height_reg = data;
				default: ;
			endcase
		endfunction

		// upper edge of the transparent band, saturated
		function int band_top(int c);
			int hi;
			hi = int'(key[c]) + int'(tol[c]);
			return (hi > 255) ? 255 : hi;
		endfunction

		function int eff_dim(logic [12:0] v);
			if (v == 0)
				return 1;
			return (v > MAX_DIM) ? MAX_DIM : int'(v);
		endfunction

		function void take_pixel(pix_t p);
			int w, h, col, row, left, right;
			bit last_col, last_img, clear, have, close;
			logic [7:0] ch [3];
			rect_t r;
			ch[0] = p.pix_red;
			ch[1] = p.pix_green;
			ch[2] = p.pix_blue;
			w = eff_dim(width_reg);
			h = eff_dim(height_reg);
			col = col_count;
			row = row_count;
			last_col = col >= w - 1;
			last_img = last_col && row >= h - 1;
			clear = 1;
			for (int c = 0; c < 3; c++)
				if (ch[c] < key[c] || int'(ch[c]) > band_top(c))
					clear = 0;
			have = 0;
			left = 0;
			right = 0;
			if (clear) begin
				if (in_run) begin
					have = 1;
					left = run_start;
					right = col;
				end
				in_run = 0;
			end else begin
				if (!in_run) begin
					run_start = col;
					in_run = 1;
				end
				if (last_col) begin
					have = 1;
					left = run_start;
					right = col + 1;
				end
			end
			if (last_col)
				in_run = 0;
			if (have) begin
				rects_in_batch++;
				if (left < box_left) box_left = left;
				if (row < box_top) box_top = row;
				if (right > box_right) box_right = right;
				if (row + 1 > box_bottom) box_bottom = row + 1;
			end
			close = (have && rects_in_batch >= BATCH_SIZE) || last_img;
			if (last_col) begin
				col_count = 0;
				row_count = last_img ? 0 : ((row + 1) & 12'hfff);
			end else begin
				col_count = (col + 1) & 12'hfff;
			end
			if (!have && !close)
				return;
			r = '0;
			if (have) begin
				r.rect_valid = 1'b1;
				r.rect_left = left[11:0];
				r.rect_right = right[12:0];
				r.rect_row = row[11:0];
			end
			if (close) begin
				r.batch_end = 1'b1;
				r.batch_count = rects_in_batch[10:0];
				r.bound_left = box_left[12:0];
				r.bound_top = box_top[12:0];
				r.bound_right = box_right[12:0];
				r.bound_bottom = box_bottom[12:0];
				clear_batch();
			end
			r.image_end = last_img;
			if (last_img) begin
				in_run = 0;
				run_start = 0;
			end
			rects_due.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task cmp(string name, longint got, longint want);
			if (got != want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task match_rect(rect_t got);
			rect_t want;
			if (rects_due.size() == 0) begin
				report("result beat with nothing outstanding");
				return;
			end
			want = rects_due.pop_front();
			cmp("rect_valid", got.rect_valid, want.rect_valid);
			cmp("rect_left", got.rect_left, want.rect_left);
			cmp("rect_right", got.rect_right, want.rect_right);
			cmp("rect_row", got.rect_row, want.rect_row);
			cmp("batch_end", got.batch_end, want.batch_end);
			cmp("batch_count", got.batch_count, want.batch_count);
			cmp("bound_left", got.bound_left, want.bound_left);
			cmp("bound_top", got.bound_top, want.bound_top);
			cmp("bound_right", got.bound_right, want.bound_right);
			cmp("bound_bottom", got.bound_bottom, want.bound_bottom);
			cmp("image_end", got.image_end, want.image_end);
		endtask

		function int pending();
			return rects_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_stall;
	pix_t        pix;
	logic        res_valid;
	logic        res_stall;
	rect_t       res;
	logic        cfg_we;
	logic [3:0]  cfg_idx;
	logic [12:0] cfg_data;

	run_rect_tracker board;
	int send_idle;
	int recv_stall;
	bit hold_go;

	color_key_run_to_rects_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stall, or a long hold-off counted down here
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				res_stall = 1'b1;
				hold_left--;
			end else begin
				res_stall = $urandom_range(99) < recv_stall;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.match_rect(res);
	end

	task automatic send_pixel(input pix_t p);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			pix_valid = 1'b0;
			@(negedge clk);
		end
		pix = p;
		pix_valid = 1'b1;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		board.take_pixel(p);
	endtask

	// stop sending, let every due result arrive, then cover the pipeline
	task automatic drain();
		@(negedge clk);
		pix_valid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [12:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic set_config(input logic [7:0] kr, kg, kb, tr, tg, tb,
			input logic [12:0] w, h);
		drain();
		write_reg(REG_KEY_RED, {5'd0, kr});
		write_reg(REG_KEY_GREEN, {5'd0, kg});
		write_reg(REG_KEY_BLUE, {5'd0, kb});
		write_reg(REG_TOL_RED, {5'd0, tr});
		write_reg(REG_TOL_GREEN, {5'd0, tg});
		write_reg(REG_TOL_BLUE, {5'd0, tb});
		write_reg(REG_IMG_WIDTH, w);
		write_reg(REG_IMG_HEIGHT, h);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [7:0] band_value(int c);
		int hi;
		hi = board.band_top(c);
		case ($urandom_range(3))
			0: return board.key[c];
			1: return hi[7:0];
			default: return 8'($urandom_range(hi, board.key[c]));
		endcase
	endfunction

	// pixel inside the key band, or pushed out of it on one channel
	function automatic pix_t make_pixel(bit opaque);
		logic [7:0] ch [3];
		int hi, c, start, k;
		for (c = 0; c < 3; c++)
			ch[c] = band_value(c);
		if (opaque) begin
			start = $urandom_range(2);
			for (int i = 0; i < 3; i++) begin
				c = (start + i) % 3;
				k = board.key[c];
				hi = board.band_top(c);
				if (k > 0 && (hi == 255 || $urandom_range(1) == 1)) begin
					ch[c] = $urandom_range(1) ? 8'(k - 1) : 8'($urandom_range(k - 1, 0));
					break;
				end else if (hi < 255) begin
					ch[c] = $urandom_range(1) ? 8'(hi + 1) : 8'($urandom_range(255, hi + 1));
					break;
				end
			end
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	function automatic logic [7:0] pick8();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [12:0] pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return 13'($urandom_range(6));
		if (r < 95)
			return 13'($urandom_range(40, 7));
		return 13'($urandom_range(8191, 4097));
	endfunction

	// new settings (often mid-image), then a stretch of mostly keyed pixels
	task automatic random_phase(input int n);
		pix_t p;
		logic [31:0] bits;
		set_config(pick8(), pick8(), pick8(), pick8(), pick8(), pick8(), pick_dim(), pick_dim());
		for (int i = 0; i < n; i++) begin
			bits = $urandom;
			if (bits[31:28] < 2)
				p = pix_t'(bits[23:0]);
			else
				p = make_pixel(bits[24]);
			send_pixel(p);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		hold_go = 1'b0;
		send_idle = 22;
		recv_stall = 85;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 1x1 images, only black is transparent
		send_pixel({8'd0, 8'd0, 8'd0});
		send_pixel({8'd255, 8'd255, 8'd255});

		// red band saturates at 255; 4x2 image
		set_config(8'd200, 8'd0, 8'd255, 8'd100, 8'd0, 8'd0, 13'd4, 13'd2);
		send_pixel({8'd255, 8'd0, 8'd255});
		send_pixel({8'd199, 8'd0, 8'd255});
		send_pixel({8'd200, 8'd1, 8'd255});
		send_pixel({8'd200, 8'd0, 8'd254});
		send_pixel({8'd0, 8'd255, 8'd0});
		send_pixel({8'd227, 8'd0, 8'd255});
		send_pixel({8'd128, 8'd128, 8'd128});
		send_pixel({8'd200, 8'd0, 8'd255});

		// zero dimensions behave as one
		set_config(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 13'd0, 13'd0);
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd254, 8'd255, 8'd255});

		// shrink the image while a run is open past the new last column, then the last row
		set_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd10, 13'd5, 13'd3);
		send_pixel({8'd17, 8'd0, 8'd10});
		send_pixel({8'd0, 8'd1, 8'd0});
		send_pixel({8'd0, 8'd0, 8'd11});
		set_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd10, 13'd2, 13'd3);
		send_pixel({8'd9, 8'd0, 8'd0});
		set_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd10, 13'd2, 13'd1);
		send_pixel({8'd0, 8'd7, 8'd0});
		send_pixel({8'd3, 8'd0, 8'd200});

		for (int i = 0; i < 6; i++)
			random_phase(100);

		drain();
		send_idle = 85;
		recv_stall = 22;
		for (int i = 0; i < 6; i++)
			random_phase(100);

		drain();
		send_idle = 0;
		recv_stall = 0;

		// receiver holds off while pixels keep coming, so the event queue fills
		set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 13'd1, 13'd7);
		hold_go = ~hold_go;
		for (int i = 0; i < 80; i++)
			send_pixel(make_pixel(1'($urandom_range(1))));

		for (int i = 0; i < 6; i++)
			random_phase(100);

		drain();
		repeat (10) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d results never arrived", board.pending()));
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[color_key_run_to_rects_top.f]
src/ckr_pkg.sv
src/ckr_front.sv
src/ckr_fifo.sv
src/ckr_back.sv
src/color_key_run_to_rects_top.sv
tb/testbench.sv
